@@ src/vgns_pkg.sv @@
// ----------------------------------------------------------------------------
// vgns_pkg - shared types and constants of the voxel grid smoother
// grid dimensions, command codes, register indexes and state encoding
// ----------------------------------------------------------------------------
package vgns_pkg;

   localparam int MaxX = 32;
   localparam int MaxY = 32;
   localparam int MaxZ = 32;
   localparam int ValueBits = 16;
   localparam int XBits = $clog2(MaxX);
   localparam int YBits = $clog2(MaxY);
   localparam int ZBits = $clog2(MaxZ);
   localparam int AddrBits = XBits + YBits + ZBits;
   localparam int CellCount = MaxX * MaxY * MaxZ;
   localparam int SumBits = ValueBits + 3;

   localparam logic [1:0] CMD_WRITE = 2'd0;
   localparam logic [1:0] CMD_RUN   = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;

   localparam logic [1:0] REG_SIZE_X = 2'd0;
   localparam logic [1:0] REG_SIZE_Y = 2'd1;
   localparam logic [1:0] REG_SIZE_Z = 2'd2;
   localparam logic [1:0] REG_PASSES = 2'd3;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RDRSP,
      ST_CELL,
      ST_FETCH,
      ST_GATHER,
      ST_DIV,
      ST_STORE,
      ST_RESP
   } state_type;

endpackage

@@ src/voxel_grid_neighbor_smoother_top.sv @@
// ----------------------------------------------------------------------------
// voxel_grid_neighbor_smoother_top - 3d six-neighbor smoothing grid
// two ping-pong banks of signed q8.8 cells with write, read and run commands
// ----------------------------------------------------------------------------
// A write item writes the bank directly and a read item waits for the
// registered memory read; each returns one result item with status 1 when the coordinate
// lies outside the configured grid. A run item performs "passes" passes over
// size_x*size_y*size_z cells; each cell costs 7 memory reads through the
// single read port of the source bank, a serial 19-step divider by the
// neighbor count and one write into the other bank.
// Only one item is in work at a time;
// the result register holds one result item, and a new item is taken only
// while that register is empty or is being emptied in the same cycle.
// Unwritten cells read as garbage, and no clearing pass exists.
module voxel_grid_neighbor_smoother_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // cmd[1:0], coord_x[6:2], coord_y[11:7], coord_z[16:12], write_value[32:17]
   input  logic [39:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // read_value[15:0], status[16]
   output logic [23:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [5:0]  csr_data
);

   localparam int VB = vgns_pkg::ValueBits;
   localparam int SB = vgns_pkg::SumBits;
   localparam int XB = vgns_pkg::XBits;
   localparam int YB = vgns_pkg::YBits;
   localparam int ZB = vgns_pkg::ZBits;
   localparam int AB = vgns_pkg::AddrBits;

   // memories
   logic [VB-1:0] bank0_mem [vgns_pkg::CellCount];
   logic [VB-1:0] bank1_mem [vgns_pkg::CellCount];
   logic [VB-1:0] rd0_ff, rd1_ff;

   // configuration
   logic [5:0] size_x_ff, size_y_ff, size_z_ff;
   logic [3:0] passes_ff;

   vgns_pkg::state_type state_ff, state_in;
   logic bank_ff, bank_in;

   // fields of the offered request item
   logic [1:0]    cmd;
   logic [XB-1:0] cx;
   logic [YB-1:0] cy;
   logic [ZB-1:0] cz;
   logic [VB-1:0] wval;
   assign cmd  = req_tdata[1:0];
   assign cx   = req_tdata[2 +: XB];
   assign cy   = req_tdata[7 +: YB];
   assign cz   = req_tdata[12 +: ZB];
   assign wval = req_tdata[17 +: VB];

   // effective sizes, clamped to 1..max
   logic [XB:0] nx;
   logic [YB:0] ny;
   logic [ZB:0] nz;
   always_comb begin
      nx = (size_x_ff == 6'd0) ? (XB+1)'(1) :
           (size_x_ff > 6'(vgns_pkg::MaxX)) ? (XB+1)'(vgns_pkg::MaxX) : size_x_ff[XB:0];
      ny = (size_y_ff == 6'd0) ? (YB+1)'(1) :
           (size_y_ff > 6'(vgns_pkg::MaxY)) ? (YB+1)'(vgns_pkg::MaxY) : size_y_ff[YB:0];
      nz = (size_z_ff == 6'd0) ? (ZB+1)'(1) :
           (size_z_ff > 6'(vgns_pkg::MaxZ)) ? (ZB+1)'(vgns_pkg::MaxZ) : size_z_ff[ZB:0];
   end

   // result register
   logic          rsp_valid_ff, rsp_valid_in;
   logic [VB-1:0] rsp_value_ff, rsp_value_in;
   logic          rsp_status_ff, rsp_status_in;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_status_ff, rsp_value_ff};

   // run sequencer registers
   logic [XB-1:0] px_ff, px_in;
   logic [YB-1:0] py_ff, py_in;
   logic [ZB-1:0] pz_ff, pz_in;
   logic [3:0]    pass_ff, pass_in;
   logic [2:0]    tap_ff, tap_in;     // 0 centre, 1..6 neighbors
   logic          tap_ok_ff, tap_ok_in;
   logic signed [SB-1:0] sum_ff, sum_in;
   logic [2:0]    cnt_ff, cnt_in;
   logic signed [VB-1:0] prev_ff, prev_in;
   // serial divider
   logic [SB-1:0] quo_ff, quo_in;
   logic [3:0]    rem_ff, rem_in;
   logic [4:0]    step_ff, step_in;
   logic          neg_ff, neg_in;
   logic [AB-1:0] raddr_ff, raddr_in;

   logic          wr_en;
   logic          wr_bank;
   logic [AB-1:0] wr_addr;
   logic [VB-1:0] wr_data;

   assign csr_ready = 1'b1;

   // tap address and bounds
   logic [XB-1:0] tx;
   logic [YB-1:0] ty;
   logic [ZB-1:0] tz;
   logic          tok;
   always_comb begin
      tx = px_ff; ty = py_ff; tz = pz_ff; tok = 1'b1;
      case (tap_in)
         3'd1: begin tx = px_ff - 1'b1; tok = (px_ff != '0); end
         3'd2: begin tx = px_ff + 1'b1; tok = ((XB+1)'(px_ff) + 1'b1 < nx); end
         3'd3: begin ty = py_ff - 1'b1; tok = (py_ff != '0); end
         3'd4: begin ty = py_ff + 1'b1; tok = ((YB+1)'(py_ff) + 1'b1 < ny); end
         3'd5: begin tz = pz_ff - 1'b1; tok = (pz_ff != '0); end
         3'd6: begin tz = pz_ff + 1'b1; tok = ((ZB+1)'(pz_ff) + 1'b1 < nz); end
         default: tok = 1'b1;
      endcase
   end

   logic signed [VB-1:0] rdata;
   assign rdata = bank_ff ? rd1_ff : rd0_ff;

   logic in_range;
   assign in_range = ((XB+1)'(cx) < nx) && ((YB+1)'(cy) < ny) && ((ZB+1)'(cz) < nz);

   logic last_x, last_y, last_z;
   assign last_x = ((XB+1)'(px_ff) + 1'b1 == nx);
   assign last_y = ((YB+1)'(py_ff) + 1'b1 == ny);
   assign last_z = ((ZB+1)'(pz_ff) + 1'b1 == nz);

   logic [SB-1:0] abs_sum;
   assign abs_sum = sum_ff[SB-1] ? SB'(-sum_ff) : SB'(sum_ff);
   logic [4:0] trial;
   assign trial = {rem_ff, quo_ff[SB-1]};
   logic signed [VB-1:0] div_res;
   assign div_res = neg_ff ? VB'(-quo_ff) : VB'(quo_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         vgns_pkg::ST_IDLE:
            if (req_tvalid && req_tready) begin
               if (cmd == vgns_pkg::CMD_READ && in_range) state_in = vgns_pkg::ST_RDRSP;
               else if (cmd == vgns_pkg::CMD_RUN && passes_ff != '0)
                  state_in = vgns_pkg::ST_CELL;
            end
         vgns_pkg::ST_RDRSP: if (!rsp_valid_ff || rsp_tready) state_in = vgns_pkg::ST_IDLE;
         vgns_pkg::ST_CELL:   state_in = vgns_pkg::ST_FETCH;
         vgns_pkg::ST_FETCH:  if (tap_ff == 3'd6) state_in = vgns_pkg::ST_GATHER;
         vgns_pkg::ST_GATHER: state_in = vgns_pkg::ST_DIV;
         vgns_pkg::ST_DIV:    if (step_ff == '0) state_in = vgns_pkg::ST_STORE;
         vgns_pkg::ST_STORE:
            if (last_x && last_y && last_z && pass_ff == 4'd1) state_in = vgns_pkg::ST_RESP;
            else state_in = vgns_pkg::ST_CELL;
         vgns_pkg::ST_RESP: if (!rsp_valid_ff || rsp_tready) state_in = vgns_pkg::ST_IDLE;
         default: state_in = vgns_pkg::ST_IDLE;
      endcase
   end

   assign req_tready = (state_ff == vgns_pkg::ST_IDLE) && (!rsp_valid_ff || rsp_tready);

   // datapath / outputs
   always_comb begin
      bank_in = bank_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_value_in = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      px_in = px_ff; py_in = py_ff; pz_in = pz_ff; pass_in = pass_ff;
      tap_in = tap_ff; tap_ok_in = tap_ok_ff; sum_in = sum_ff; cnt_in = cnt_ff;
      prev_in = prev_ff; quo_in = quo_ff; rem_in = rem_ff; step_in = step_ff;
      neg_in = neg_ff; raddr_in = raddr_ff;
      wr_en = 1'b0; wr_bank = bank_ff;
      wr_addr = {cz, cy, cx}; wr_data = wval;
      case (state_ff)
         vgns_pkg::ST_IDLE:
            if (req_tvalid && req_tready) begin
               raddr_in = {cz, cy, cx};
               rsp_value_in = '0;
               rsp_status_in = (cmd == vgns_pkg::CMD_WRITE || cmd == vgns_pkg::CMD_READ)
                               && !in_range;
               rsp_valid_in = !(cmd == vgns_pkg::CMD_READ && in_range) &&
                              !(cmd == vgns_pkg::CMD_RUN && passes_ff != '0);
               if (cmd == vgns_pkg::CMD_WRITE && in_range) wr_en = 1'b1;
               px_in = '0; py_in = '0; pz_in = '0; pass_in = passes_ff;
            end
         vgns_pkg::ST_RDRSP:
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1; rsp_value_in = rdata; rsp_status_in = 1'b0;
            end
         vgns_pkg::ST_CELL: begin
            tap_in = 3'd0; sum_in = '0; cnt_in = '0;
            raddr_in = {pz_ff, py_ff, px_ff}; tap_ok_in = 1'b1;
         end
         vgns_pkg::ST_FETCH: begin
            // data of tap_ff is back; accumulate and issue next
            if (tap_ff == 3'd0) prev_in = rdata;
            else if (tap_ok_ff) begin
               sum_in = sum_ff + SB'(rdata);
               cnt_in = cnt_ff + 1'b1;
            end
            if (tap_ff != 3'd6) begin
               tap_in = tap_ff + 1'b1;
               raddr_in = {tz, ty, tx}; tap_ok_in = tok;
            end
         end
         vgns_pkg::ST_GATHER: begin
            neg_in = sum_ff[SB-1];
            quo_in = abs_sum; rem_in = '0; step_in = 5'(SB);
         end
         vgns_pkg::ST_DIV:
            if (step_ff != '0) begin
               step_in = step_ff - 1'b1;
               if (trial >= {2'b00, cnt_ff}) begin
                  rem_in = 4'(trial - {2'b00, cnt_ff});
                  quo_in = {quo_ff[SB-2:0], 1'b1};
               end else begin
                  rem_in = trial[3:0];
                  quo_in = {quo_ff[SB-2:0], 1'b0};
               end
            end
         vgns_pkg::ST_STORE: begin
            wr_en = 1'b1; wr_bank = !bank_ff;
            wr_addr = {pz_ff, py_ff, px_ff};
            wr_data = (cnt_ff == '0 || prev_ff < div_res) ? prev_ff : div_res;
            px_in = px_ff + 1'b1;
            if (last_x) begin
               px_in = '0; py_in = py_ff + 1'b1;
               if (last_y) begin
                  py_in = '0; pz_in = pz_ff + 1'b1;
                  if (last_z) begin
                     pz_in = '0; pass_in = pass_ff - 1'b1; bank_in = !bank_ff;
                  end
               end
            end
         end
         vgns_pkg::ST_RESP:
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1; rsp_value_in = '0; rsp_status_in = 1'b0;
            end
         default: ;
      endcase
   end

   // memories: one write and one registered read port each
   always_ff @(posedge clock) begin
      if (wr_en && !wr_bank) bank0_mem[wr_addr] <= wr_data;
      rd0_ff <= bank0_mem[raddr_in];
   end
   always_ff @(posedge clock) begin
      if (wr_en && wr_bank) bank1_mem[wr_addr] <= wr_data;
      rd1_ff <= bank1_mem[raddr_in];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= vgns_pkg::ST_IDLE;
         bank_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         size_x_ff <= 6'd32; size_y_ff <= 6'd32; size_z_ff <= 6'd32;
         passes_ff <= 4'd5;
      end else begin
         state_ff <= state_in;
         bank_ff <= bank_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               vgns_pkg::REG_SIZE_X: size_x_ff <= csr_data;
               vgns_pkg::REG_SIZE_Y: size_y_ff <= csr_data;
               vgns_pkg::REG_SIZE_Z: size_z_ff <= csr_data;
               vgns_pkg::REG_PASSES: passes_ff <= csr_data[3:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff <= rsp_value_in; rsp_status_ff <= rsp_status_in;
      px_ff <= px_in; py_ff <= py_in; pz_ff <= pz_in; pass_ff <= pass_in;
      tap_ff <= tap_in; tap_ok_ff <= tap_ok_in; sum_ff <= sum_in; cnt_ff <= cnt_in;
      prev_ff <= prev_in; quo_ff <= quo_in; rem_ff <= rem_in; step_ff <= step_in;
      neg_ff <= neg_in; raddr_ff <= raddr_in;
   end

endmodule

@@ test/vgns_checker.sv @@
// ----------------------------------------------------------------------------
// vgns_checker - result predictor and scoreboard for the voxel grid smoother
// follows register writes and accepted request items, keeps its own copy of
// both cell banks, and compares every accepted response item with the oldest
// expected response
// ----------------------------------------------------------------------------
module vgns_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [39:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [23:0] rsp_tdata,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [5:0]  csr_data,
   output int          fail_count,
   output int          pending
);

   typedef struct packed {
      logic [15:0] read_value;
      logic        status;
   } voxel_result_type;

   logic signed [vgns_pkg::ValueBits-1:0] grid_mem [2][vgns_pkg::CellCount];
   logic             cur_bank;
   logic [5:0]       size_reg [3];
   logic [3:0]       passes_reg;
   voxel_result_type expected_q [$];

   function automatic int clamp_size(logic [5:0] v, int maxv);
      if (v == 6'd0) return 1;
      if (int'(v) > maxv) return maxv;
      return int'(v);
   endfunction

   function automatic int cell_addr(int x, int y, int z);
      return (z * vgns_pkg::MaxY + y) * vgns_pkg::MaxX + x;
   endfunction

   // one smoothing pass from the current bank into the other one
   task automatic smooth_once(int nx, int ny, int nz);
      int sum;
      int cnt;
      int prev;
      int v;
      for (int z = 0; z < nz; z++)
         for (int y = 0; y < ny; y++)
            for (int x = 0; x < nx; x++) begin
               sum = 0;
               cnt = 0;
               prev = int'(grid_mem[cur_bank][cell_addr(x, y, z)]);
               if (x > 0) begin
                  sum += int'(grid_mem[cur_bank][cell_addr(x-1, y, z)]); cnt++;
               end
               if (x + 1 < nx) begin
                  sum += int'(grid_mem[cur_bank][cell_addr(x+1, y, z)]); cnt++;
               end
               if (y > 0) begin
                  sum += int'(grid_mem[cur_bank][cell_addr(x, y-1, z)]); cnt++;
               end
               if (y + 1 < ny) begin
                  sum += int'(grid_mem[cur_bank][cell_addr(x, y+1, z)]); cnt++;
               end
               if (z > 0) begin
                  sum += int'(grid_mem[cur_bank][cell_addr(x, y, z-1)]); cnt++;
               end
               if (z + 1 < nz) begin
                  sum += int'(grid_mem[cur_bank][cell_addr(x, y, z+1)]); cnt++;
               end
               // isolated cell keeps its value; division truncates toward zero
               v = (cnt == 0) ? prev : sum / cnt;
               if (prev < v) v = prev;
               grid_mem[!cur_bank][cell_addr(x, y, z)] = v[vgns_pkg::ValueBits-1:0];
            end
      cur_bank = !cur_bank;
   endtask

   task automatic predict_item(logic [39:0] data);
      logic [1:0]       cmd;
      int               x;
      int               y;
      int               z;
      int               nx;
      int               ny;
      int               nz;
      voxel_result_type res;
      cmd = data[1:0];
      x = int'(data[6:2]);
      y = int'(data[11:7]);
      z = int'(data[16:12]);
      nx = clamp_size(size_reg[0], vgns_pkg::MaxX);
      ny = clamp_size(size_reg[1], vgns_pkg::MaxY);
      nz = clamp_size(size_reg[2], vgns_pkg::MaxZ);
      res = '0;
      if (cmd == vgns_pkg::CMD_WRITE || cmd == vgns_pkg::CMD_READ) begin
         if (x >= nx || y >= ny || z >= nz) res.status = 1'b1;
         else if (cmd == vgns_pkg::CMD_WRITE)
            grid_mem[cur_bank][cell_addr(x, y, z)] = data[32:17];
         else res.read_value = grid_mem[cur_bank][cell_addr(x, y, z)];
      end else if (cmd == vgns_pkg::CMD_RUN) begin
         for (int p = 0; p < int'(passes_reg); p++) smooth_once(nx, ny, nz);
      end
      expected_q.push_back(res);
   endtask

   always @(posedge clock) begin
      voxel_result_type want;
      if (reset) begin
         cur_bank = 1'b0;
         size_reg[0] <= 6'd32;
         size_reg[1] <= 6'd32;
         size_reg[2] <= 6'd32;
         passes_reg <= 4'd5;
         expected_q.delete();
         fail_count <= 0;
         pending <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               vgns_pkg::REG_SIZE_X: size_reg[0] <= csr_data;
               vgns_pkg::REG_SIZE_Y: size_reg[1] <= csr_data;
               vgns_pkg::REG_SIZE_Z: size_reg[2] <= csr_data;
               vgns_pkg::REG_PASSES: passes_reg <= csr_data[3:0];
               default: ;
            endcase
         end
         // response compare first so a result never meets its own prediction
         if (rsp_tvalid && rsp_tready) begin
            if (expected_q.size() == 0) begin
               if (fail_count < 10)
                  $display("unexpected response item: read_value %h status %b",
                           rsp_tdata[15:0], rsp_tdata[16]);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_q.pop_front();
               if (want.read_value !== rsp_tdata[15:0] || want.status !== rsp_tdata[16]) begin
                  if (fail_count < 10)
                     $display("response mismatch: read_value exp %h got %h, status exp %b got %b",
                              want.read_value, rsp_tdata[15:0], want.status, rsp_tdata[16]);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_tvalid && req_tready) predict_item(req_tdata);
         pending <= expected_q.size();
      end
   end

endmodule

@@ test/tb.sv @@
// ----------------------------------------------------------------------------
// tb - testbench top of the voxel grid smoother
// drives write, read and run items over several grid shapes and pass counts
// with random sender gaps and receiver stalls; a checker predicts responses
// ----------------------------------------------------------------------------
module tb;

   localparam int WatchLimit = 120000;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [5:0]  csr_data;
   int          fail_count;
   int          pending;

   // stimulus-side view of the grid: which cells hold a written value
   bit          written [2][vgns_pkg::CellCount];
   bit          shadow_bank;
   int          cfg_size [3];
   int          cfg_passes;
   // idling percentages, and the long receiver hold-off flag
   int          snd_idle;
   int          rcv_stall;
   bit          rsp_hold;
   int          quiet_cycles = 0;

   voxel_grid_neighbor_smoother_top i_dut (.*);

   vgns_checker i_checker (.*);

   always #2 clock = ~clock;

   // receiver: random stalls, or a long hold-off while rsp_hold is set
   always @(negedge clock)
      rsp_tready <= !rsp_hold && (int'($urandom_range(99)) >= rcv_stall);

   // watchdog on cycles without any accepted item
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchLimit) begin
         $display("status: fail");
         $finish;
      end
   end

   function automatic int axis_len(int v, int maxv);
      if (v == 0) return 1;
      if (v > maxv) return maxv;
      return v;
   endfunction

   function automatic int cell_addr(int x, int y, int z);
      return (z * vgns_pkg::MaxY + y) * vgns_pkg::MaxX + x;
   endfunction

   function automatic bit in_grid(int x, int y, int z);
      return x < axis_len(cfg_size[0], vgns_pkg::MaxX)
             && y < axis_len(cfg_size[1], vgns_pkg::MaxY)
             && z < axis_len(cfg_size[2], vgns_pkg::MaxZ);
   endfunction

   // every cell of the active grid written in the current bank
   function automatic bit grid_ready();
      for (int z = 0; z < axis_len(cfg_size[2], vgns_pkg::MaxZ); z++)
         for (int y = 0; y < axis_len(cfg_size[1], vgns_pkg::MaxY); y++)
            for (int x = 0; x < axis_len(cfg_size[0], vgns_pkg::MaxX); x++)
               if (!written[shadow_bank][cell_addr(x, y, z)]) return 1'b0;
      return 1'b1;
   endfunction

   // one request item, entered and left at a falling edge
   task automatic send_item(logic [1:0] cmd, int x, int y, int z, logic [15:0] val);
      while (int'($urandom_range(99)) < snd_idle) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {7'd0, val, z[4:0], y[4:0], x[4:0], cmd};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      if (cmd == vgns_pkg::CMD_WRITE && in_grid(x, y, z))
         written[shadow_bank][cell_addr(x, y, z)] = 1'b1;
      if (cmd == vgns_pkg::CMD_RUN && cfg_passes > 0) begin
         // a pass fills the target bank over the whole active grid
         for (int zz = 0; zz < axis_len(cfg_size[2], vgns_pkg::MaxZ); zz++)
            for (int yy = 0; yy < axis_len(cfg_size[1], vgns_pkg::MaxY); yy++)
               for (int xx = 0; xx < axis_len(cfg_size[0], vgns_pkg::MaxX); xx++)
                  written[!shadow_bank][cell_addr(xx, yy, zz)] = 1'b1;
         shadow_bank ^= cfg_passes[0];
      end
   endtask

   // wait until every expected response has come back
   task automatic drain();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [5:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      if (idx == vgns_pkg::REG_PASSES) cfg_passes = int'(val[3:0]);
      else cfg_size[idx] = int'(val);
   endtask

   task automatic set_shape(logic [5:0] sx, logic [5:0] sy, logic [5:0] sz, logic [5:0] np);
      drain();
      write_reg(vgns_pkg::REG_SIZE_X, sx);
      write_reg(vgns_pkg::REG_SIZE_Y, sy);
      write_reg(vgns_pkg::REG_SIZE_Z, sz);
      write_reg(vgns_pkg::REG_PASSES, np);
   endtask

   // write every still unwritten cell of the active grid
   task automatic fill_grid();
      for (int z = 0; z < axis_len(cfg_size[2], vgns_pkg::MaxZ); z++)
         for (int y = 0; y < axis_len(cfg_size[1], vgns_pkg::MaxY); y++)
            for (int x = 0; x < axis_len(cfg_size[0], vgns_pkg::MaxX); x++)
               if (!written[shadow_bank][cell_addr(x, y, z)])
                  send_item(vgns_pkg::CMD_WRITE, x, y, z, 16'($urandom_range(16'hffff)));
   endtask

   task automatic random_items(int count);
      int          pick;
      int          x;
      int          y;
      int          z;
      logic [15:0] val;
      for (int n = 0; n < count; n++) begin
         pick = int'($urandom_range(99));
         val = 16'($urandom_range(16'hffff));
         if (pick < 85) begin
            x = int'($urandom_range(axis_len(cfg_size[0], vgns_pkg::MaxX) - 1));
            y = int'($urandom_range(axis_len(cfg_size[1], vgns_pkg::MaxY) - 1));
            z = int'($urandom_range(axis_len(cfg_size[2], vgns_pkg::MaxZ) - 1));
         end else begin
            // anywhere, mostly outside the active grid
            x = int'($urandom_range(31));
            y = int'($urandom_range(31));
            z = int'($urandom_range(31));
         end
         if (pick < 40 || pick >= 85 && pick < 90) begin
            send_item(vgns_pkg::CMD_WRITE, x, y, z, val);
         end else if (pick < 75 || pick >= 90 && pick < 95) begin
            // never read a cell that holds no value yet
            if (in_grid(x, y, z) && !written[shadow_bank][cell_addr(x, y, z)])
               send_item(vgns_pkg::CMD_WRITE, x, y, z, val);
            else
               send_item(vgns_pkg::CMD_READ, x, y, z, val);
         end else if (pick < 82) begin
            if (grid_ready()) send_item(vgns_pkg::CMD_RUN, x, y, z, val);
            else fill_grid();
         end else begin
            // unused command code: no operation
            send_item(CMD_UNUSED, x, y, z, val);
         end
      end
   endtask

   task automatic set_idling(int mode);
      case (mode % 4)
         0: begin snd_idle = 0; rcv_stall = 0; end
         1: begin snd_idle = 88; rcv_stall = 0; end
         2: begin snd_idle = 0; rcv_stall = 88; end
         default: begin snd_idle = 17; rcv_stall = 17; end
      endcase
   endtask

   initial begin
      reset = 1;
      req_tvalid = 0;
      req_tdata = '0;
      csr_valid = 0;
      csr_index = vgns_pkg::REG_SIZE_X;
      csr_data = '0;
      snd_idle = 0;
      rcv_stall = 0;
      rsp_hold = 0;
      shadow_bank = 0;
      cfg_size = '{32, 32, 32};
      cfg_passes = 5;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: full-size grid corners and extreme values, no run here
      send_item(vgns_pkg::CMD_WRITE, 0, 0, 0, 16'h8000);
      send_item(vgns_pkg::CMD_WRITE, 31, 31, 31, 16'h7fff);
      send_item(vgns_pkg::CMD_READ, 0, 0, 0, 16'h0000);
      send_item(vgns_pkg::CMD_READ, 31, 31, 31, 16'hffff);
      send_item(CMD_UNUSED, 31, 31, 31, 16'hffff);

      // directed: 2x2x2 grid, one pass, then coordinates just outside
      set_shape(6'd2, 6'd2, 6'd2, 6'd1);
      fill_grid();
      send_item(vgns_pkg::CMD_RUN, 31, 31, 31, 16'hffff);
      send_item(vgns_pkg::CMD_READ, 1, 1, 1, 16'h0000);
      send_item(vgns_pkg::CMD_WRITE, 2, 0, 0, 16'h1234);
      send_item(vgns_pkg::CMD_READ, 0, 2, 0, 16'h0000);
      send_item(vgns_pkg::CMD_READ, 0, 0, 2, 16'h0000);

      // directed: size zero acts as one, isolated cell keeps its value
      set_shape(6'd0, 6'd0, 6'd0, 6'd3);
      send_item(vgns_pkg::CMD_WRITE, 0, 0, 0, 16'hff80);
      send_item(vgns_pkg::CMD_RUN, 0, 0, 0, 16'h0000);
      send_item(vgns_pkg::CMD_READ, 0, 0, 0, 16'h0000);
      send_item(vgns_pkg::CMD_READ, 1, 0, 0, 16'h0000);

      // directed: oversized x acts as the maximum, zero passes change nothing
      set_shape(6'd63, 6'd1, 6'd1, 6'd0);
      fill_grid();
      send_item(vgns_pkg::CMD_RUN, 0, 0, 0, 16'h0000);
      send_item(vgns_pkg::CMD_READ, 31, 0, 0, 16'h0000);

      // long lines along each axis, deepest pass count on one of them
      set_idling(1);
      set_shape(6'd32, 6'd1, 6'd1, 6'd2);
      random_items(40);
      set_idling(2);
      set_shape(6'd1, 6'd32, 6'd1, 6'd15);
      fill_grid();
      random_items(40);
      set_idling(3);
      set_shape(6'd1, 6'd1, 6'd32, 6'd4);
      fill_grid();
      random_items(40);

      // receiver holds off for a long stretch while writes keep coming
      set_idling(0);
      set_shape(6'd4, 6'd4, 6'd2, 6'd1);
      fork
         begin
            @(posedge clock);
            rsp_hold = 1;
            repeat (300) @(posedge clock);
            rsp_hold = 0;
         end
      join_none
      fill_grid();

      // small random shapes across all idling patterns
      for (int ph = 0; ph < 8; ph++) begin
         set_idling(ph);
         set_shape(6'($urandom_range(1, 4)), 6'($urandom_range(1, 3)),
                   6'($urandom_range(1, 2)), 6'($urandom_range(0, 15)));
         fill_grid();
         random_items(30);
      end

      drain();
      repeat (40) @(posedge clock);
      if (fail_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
